FILE: rtl/core/sfp_pkg.sv
package sfp_pkg;

  // Build-time limits of the payload buffer.
  localparam int unsigned MAX_PAYLOAD_DEF = 32;
  localparam int unsigned MAX_PAYLOAD_LIM = 64;
  localparam int unsigned PLEN_W          = $clog2(MAX_PAYLOAD_LIM + 1);

  // Frame format.
  localparam logic [7:0]  HDR_FIRST    = 8'h42;
  localparam logic [7:0]  HDR_SECOND   = 8'h4D;
  localparam int unsigned LEN_OVERHEAD = 2;

  // Result format.
  localparam int unsigned MAX_WORDS = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned PBYTES_W  = 6;

  // Frame descriptor queue between the parser and the drain.
  localparam int unsigned DESC_DEPTH = 2;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_CHK_HI,
    PH_CHK_LO
  } phase_e;

  typedef enum logic {
    DR_IDLE,
    DR_WORDS
  } drain_e;

  typedef struct packed {
    logic              ok;
    logic [PLEN_W-1:0] plen;
  } desc_t;

  typedef struct packed {
    logic       en;
    logic       lane;
    logic [7:0] data;
  } wr_t;

endpackage

FILE: rtl/core/sfp_fifo.sv
module sfp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfp_pkg::desc_t desc_i,
  input  logic          pop_i,
  output sfp_pkg::desc_t desc_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (sfp_pkg::DESC_DEPTH > 1) ? $clog2(sfp_pkg::DESC_DEPTH) : 1;

  sfp_pkg::desc_t entries_q [sfp_pkg::DESC_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (PtrW + 1)'(sfp_pkg::DESC_DEPTH));
  assign empty_o = (count_q == '0);
  assign desc_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(sfp_pkg::DESC_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(sfp_pkg::DESC_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= desc_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("descriptor pushed into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("descriptor popped from an empty queue");
`endif

endmodule

FILE: rtl/core/sfp_front.sv
module sfp_front #(
  parameter int unsigned MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     rx_byte_i,
  input  logic           back_busy_i,
  input  logic           desc_full_i,
  output logic           desc_push_o,
  output sfp_pkg::desc_t desc_o,
  output sfp_pkg::wr_t   wr_o,
  output logic [((((MAX_PAYLOAD + 1) / 2) > 1) ? $clog2((MAX_PAYLOAD + 1) / 2) : 1)-1:0]
                         wr_addr_o
);

  localparam int unsigned Words = (MAX_PAYLOAD + 1) / 2;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned PosW  = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] LenMax = 16'(MAX_PAYLOAD + sfp_pkg::LEN_OVERHEAD);
  localparam logic [15:0] LenMin = 16'(sfp_pkg::LEN_OVERHEAD);

  sfp_pkg::phase_e phase_q, phase_d;
  logic [15:0]     sum_q, sum_d;
  logic [7:0]      chk_hi_q, chk_hi_d;
  logic [PosW-1:0] plen_q, plen_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic        acc;
  logic [15:0] len;
  logic [15:0] sum_add;
  logic        len_bad;
  logic        data_last;

  assign acc       = in_valid_i && !in_stall_o;
  assign len       = {chk_hi_q, rx_byte_i};
  assign sum_add   = sum_q + {8'h00, rx_byte_i};
  assign len_bad   = (len < LenMin) || (len > LenMax);
  assign data_last = (PosW'(pos_q + 1'b1) == plen_q);

  // Next state.
  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      unique case (phase_q)
        sfp_pkg::PH_HUNT1: begin
          phase_d = (rx_byte_i == sfp_pkg::HDR_FIRST) ? sfp_pkg::PH_HUNT2 : sfp_pkg::PH_HUNT1;
        end
        sfp_pkg::PH_HUNT2: begin
          if (rx_byte_i == sfp_pkg::HDR_SECOND) begin
            phase_d = sfp_pkg::PH_LEN_HI;
          end else if (rx_byte_i == sfp_pkg::HDR_FIRST) begin
            phase_d = sfp_pkg::PH_HUNT2;
          end else begin
            phase_d = sfp_pkg::PH_HUNT1;
          end
        end
        sfp_pkg::PH_LEN_HI: phase_d = sfp_pkg::PH_LEN_LO;
        sfp_pkg::PH_LEN_LO: begin
          if (len_bad) begin
            phase_d = sfp_pkg::PH_HUNT1;
          end else if (len == LenMin) begin
            phase_d = sfp_pkg::PH_CHK_HI;
          end else begin
            phase_d = sfp_pkg::PH_DATA;
          end
        end
        sfp_pkg::PH_DATA:   phase_d = data_last ? sfp_pkg::PH_CHK_HI : sfp_pkg::PH_DATA;
        sfp_pkg::PH_CHK_HI: phase_d = sfp_pkg::PH_CHK_LO;
        sfp_pkg::PH_CHK_LO: phase_d = sfp_pkg::PH_HUNT1;
        default:            phase_d = sfp_pkg::PH_HUNT1;
      endcase
    end
  end

  // Outputs. Payload bytes wait while the drain still reads the previous frame
  // out of the buffer, and the last checksum byte waits while the queue is full.
  always_comb begin
    in_stall_o  = ((phase_q == sfp_pkg::PH_DATA) && back_busy_i) ||
                  ((phase_q == sfp_pkg::PH_CHK_LO) && desc_full_i);
    wr_o.en     = acc && (phase_q == sfp_pkg::PH_DATA);
    wr_o.lane   = pos_q[0];
    wr_o.data   = rx_byte_i;
    wr_addr_o   = pos_q[AddrW:1];
    desc_push_o = acc && (phase_q == sfp_pkg::PH_CHK_LO);
    desc_o.ok   = (len == sum_q);
    desc_o.plen = sfp_pkg::PLEN_W'(plen_q);
  end

  always_comb begin
    sum_d    = sum_q;
    chk_hi_d = chk_hi_q;
    plen_d   = plen_q;
    pos_d    = pos_q;
    if (acc) begin
      case (phase_q)
        sfp_pkg::PH_HUNT1: sum_d = {8'h00, rx_byte_i};
        sfp_pkg::PH_HUNT2: begin
          sum_d = (rx_byte_i == sfp_pkg::HDR_SECOND) ? sum_add : {8'h00, rx_byte_i};
        end
        sfp_pkg::PH_LEN_HI: begin
          sum_d    = sum_add;
          chk_hi_d = rx_byte_i;
        end
        sfp_pkg::PH_LEN_LO: begin
          sum_d  = sum_add;
          plen_d = PosW'(len - LenMin);
          pos_d  = '0;
        end
        sfp_pkg::PH_DATA: begin
          sum_d = sum_add;
          pos_d = PosW'(pos_q + 1'b1);
        end
        sfp_pkg::PH_CHK_HI: chk_hi_d = rx_byte_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfp_pkg::PH_HUNT1;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    chk_hi_q <= chk_hi_d;
    plen_q   <= plen_d;
    pos_q    <= pos_d;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_o.en |-> !back_busy_i)
    else $error("payload buffer written while the drain may still read it");
`endif

endmodule

FILE: rtl/core/sfp_back.sv
module sfp_back #(
  parameter int unsigned MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfp_pkg::wr_t                  wr_i,
  input  logic [((((MAX_PAYLOAD + 1) / 2) > 1) ? $clog2((MAX_PAYLOAD + 1) / 2) : 1)-1:0]
                                        wr_addr_i,
  input  logic                          desc_empty_i,
  input  sfp_pkg::desc_t                desc_i,
  output logic                          desc_pop_o,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          checksum_ok_o,
  output logic                          has_word_o,
  output logic [sfp_pkg::IDX_W-1:0]     word_index_o,
  output logic [15:0]                   word_value_o,
  output logic [sfp_pkg::PBYTES_W-1:0]  payload_bytes_o,
  output logic                          last_o
);

  localparam int unsigned Words = (MAX_PAYLOAD + 1) / 2;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned PlenW = sfp_pkg::PLEN_W;
  localparam int unsigned IdxW  = sfp_pkg::IDX_W;

  sfp_pkg::drain_e state_q, state_d;

  logic [15:0]      mem_q [Words];
  logic [15:0]      rdata_q;
  logic [IdxW-1:0]  k_q, nlast_q;
  logic [PlenW-1:0] plen_q;

  logic             valid_q, valid_d;
  logic             ok_q, has_word_q, last_q;
  logic [IdxW-1:0]  idx_q;
  logic [15:0]      value_q;
  logic [sfp_pkg::PBYTES_W-1:0] pbytes_q;

  logic             out_free;
  logic             word_frame;
  logic             k_last;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             load_single;
  logic             load_word;
  logic [PlenW-1:0] half_m1;
  logic [IdxW-1:0]  nlast_d;
  logic [7:0]       lo_byte;

  assign out_free   = !valid_q || !out_stall_i;
  assign word_frame = desc_i.ok && (desc_i.plen != '0);
  assign k_last     = (k_q == nlast_q);
  assign busy_o     = (state_q != sfp_pkg::DR_IDLE) || !desc_empty_i;

  // Index of the last word: (plen - 1) / 2, capped by the result limit.
  assign half_m1 = (desc_i.plen - PlenW'(1)) >> 1;
  assign nlast_d = (half_m1 > PlenW'(sfp_pkg::MAX_WORDS - 1)) ?
                   IdxW'(sfp_pkg::MAX_WORDS - 1) : half_m1[IdxW-1:0];

  // An odd payload pads its final word with a zero low byte.
  assign lo_byte = (PlenW'({k_q, 1'b1}) < plen_q) ? rdata_q[7:0] : 8'h00;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfp_pkg::DR_IDLE: begin
        if (!desc_empty_i && word_frame) begin
          state_d = sfp_pkg::DR_WORDS;
        end
      end
      sfp_pkg::DR_WORDS: begin
        if (out_free && k_last) begin
          state_d = sfp_pkg::DR_IDLE;
        end
      end
      default: state_d = sfp_pkg::DR_IDLE;
    endcase
  end

  // Outputs. The buffer read for the next word goes out in the same cycle
  // as the current word is loaded, so words leave one per cycle unless stalled.
  always_comb begin
    desc_pop_o  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    load_single = 1'b0;
    load_word   = 1'b0;
    unique case (state_q)
      sfp_pkg::DR_IDLE: begin
        if (!desc_empty_i) begin
          if (word_frame) begin
            desc_pop_o = 1'b1;
            rd_en      = 1'b1;
          end else if (out_free) begin
            desc_pop_o  = 1'b1;
            load_single = 1'b1;
          end
        end
      end
      sfp_pkg::DR_WORDS: begin
        if (out_free) begin
          load_word = 1'b1;
          if (!k_last) begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(k_q + 1'b1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (wr_i.lane) begin
        mem_q[wr_addr_i][7:0] <= wr_i.data;
      end else begin
        mem_q[wr_addr_i][15:8] <= wr_i.data;
      end
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_pop_o && word_frame) begin
      plen_q  <= desc_i.plen;
      nlast_q <= nlast_d;
      k_q     <= '0;
    end else if (load_word && !k_last) begin
      k_q <= k_q + 1'b1;
    end
  end

  always_comb begin
    if (load_single || load_word) begin
      valid_d = 1'b1;
    end else begin
      valid_d = valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfp_pkg::DR_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_single) begin
      ok_q       <= desc_i.ok;
      has_word_q <= 1'b0;
      idx_q      <= '0;
      value_q    <= '0;
      pbytes_q   <= desc_i.plen[sfp_pkg::PBYTES_W-1:0];
      last_q     <= 1'b1;
    end else if (load_word) begin
      ok_q       <= 1'b1;
      has_word_q <= 1'b1;
      idx_q      <= k_q;
      value_q    <= {rdata_q[15:8], lo_byte};
      pbytes_q   <= plen_q[sfp_pkg::PBYTES_W-1:0];
      last_q     <= k_last;
    end
  end

  assign out_valid_o     = valid_q;
  assign checksum_ok_o   = ok_q;
  assign has_word_o      = has_word_q;
  assign word_index_o    = idx_q;
  assign word_value_o    = value_q;
  assign payload_bytes_o = pbytes_q;
  assign last_o          = last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sfp_pkg::DR_WORDS) |-> (k_q <= nlast_q))
    else $error("word counter ran past the last word of the frame");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !has_word_q) |-> last_q)
    else $error("verdict result not marked as the end of its frame");
`endif

endmodule

FILE: rtl/core/sensor_frame_parser.sv
// Serial frame parser with an additive 16-bit checksum.
// Input channel: one received byte per transaction on rx_byte_i, qualified by
// in_valid_i and held off by in_stall_o. Output channel: one result per
// transaction on out_valid_o, held off by out_stall_i.
// The parser hunts for the 0x42 0x4D header, reads a big-endian length and
// buffers the payload; at the final checksum byte it queues a frame record.
// A bad checksum, or a good one with an empty payload, gives one result;
// a good frame gives its payload as big-endian words, one result per word.
// A single-result frame passes the record queue and the output register after
// its last byte is taken; the first word of a good frame also passes the buffer
// read register. Further words follow one per cycle while the receiver does not
// stall. Throughput: one byte per cycle. Payload bytes are held off while the
// previous frame is still being read out of the payload buffer, and the last
// checksum byte is held off while two frame records wait in the queue.
// A stalled result holds its value. Reset returns the parser to header hunt
// and empties the queue and the output register.
module sensor_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         checksum_ok_o,
  output logic                         has_word_o,
  output logic [sfp_pkg::IDX_W-1:0]    word_index_o,
  output logic [15:0]                  word_value_o,
  output logic [sfp_pkg::PBYTES_W-1:0] payload_bytes_o,
  output logic                         last_o
);

  localparam int unsigned Words = (MAX_PAYLOAD + 1) / 2;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;

  sfp_pkg::desc_t   push_desc, head_desc;
  sfp_pkg::wr_t     wr;
  logic [AddrW-1:0] wr_addr;
  logic             desc_push, desc_pop, desc_full, desc_empty;
  logic             back_busy;

  sfp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .back_busy_i (back_busy),
    .desc_full_i (desc_full),
    .desc_push_o (desc_push),
    .desc_o      (push_desc),
    .wr_o        (wr),
    .wr_addr_o   (wr_addr)
  );

  sfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .desc_i  (push_desc),
    .pop_i   (desc_pop),
    .desc_o  (head_desc),
    .full_o  (desc_full),
    .empty_o (desc_empty)
  );

  sfp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .wr_addr_i       (wr_addr),
    .desc_empty_i    (desc_empty),
    .desc_i          (head_desc),
    .desc_pop_o      (desc_pop),
    .busy_o          (back_busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .checksum_ok_o   (checksum_ok_o),
    .has_word_o      (has_word_o),
    .word_index_o    (word_index_o),
    .word_value_o    (word_value_o),
    .payload_bytes_o (payload_bytes_o),
    .last_o          (last_o)
  );

endmodule
